// ===== hdl/bstk_pkg.sv =====
// Shared types and constants for the bounded stack with search.
// Holds the request/response structs and the controller/datapath command and status bundles.
// No dependencies.
package bstk_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_SEARCH  = 3'd2;
    localparam logic [2:0] OP_REVERSE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [31:0] operand_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic        [3:0]  found_index;
        logic        [1:0]  status;
        logic        [4:0]  fill_count;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       wr_push;
        logic       pop_rd;
        logic       clr;
        logic       srch_init;
        logic       srch_step;
        logic       rev_init;
        logic       rev_rd;
        logic       rev_wlo;
        logic       rev_whi;
        logic       set_st;
        logic [1:0] st;
        logic       pop_sel;
        logic       set_found;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       multi;
        logic       hit;
        logic       miss_last;
        logic       rev_more;
        logic       busy;
    } sts_t;

endpackage

// ===== hdl/bstk_ctrl.sv =====
// Sequencing state machine for the bounded stack.
// Issues bstk_pkg::cmd_t commands to the datapath and reads back bstk_pkg::sts_t.
// Depends on bstk_pkg.
module bstk_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bstk_pkg::sts_t sts,
    output bstk_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SRCH    = 3'd2;
    localparam logic [2:0] S_REV_CHK = 3'd3;
    localparam logic [2:0] S_REV_WLO = 3'd4;
    localparam logic [2:0] S_REV_WHI = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.set_st = 1'b1;
                cmd.st     = bstk_pkg::ST_OK;
                state_next = S_DONE;
                unique case (sts.op)
                    bstk_pkg::OP_PUSH:
                    begin
                        if (sts.full)
                        begin
                            cmd.st = bstk_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.wr_push = 1'b1;
                        end
                    end
                    bstk_pkg::OP_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.st = bstk_pkg::ST_UNDERFLOW;
                        end
                        else
                        begin
                            cmd.pop_rd  = 1'b1;
                            cmd.pop_sel = 1'b1;
                        end
                    end
                    bstk_pkg::OP_SEARCH:
                    begin
                        cmd.st        = bstk_pkg::ST_NOT_FOUND;
                        cmd.srch_init = 1'b1;
                        if (!sts.empty)
                        begin
                            state_next = S_SRCH;
                        end
                    end
                    bstk_pkg::OP_REVERSE:
                    begin
                        cmd.rev_init = 1'b1;
                        if (sts.multi)
                        begin
                            state_next = S_REV_CHK;
                        end
                    end
                    bstk_pkg::OP_CLEAR:
                    begin
                        cmd.clr = 1'b1;
                    end
                    default:
                    begin
                        cmd.st = bstk_pkg::ST_OK;
                    end
                endcase
            end
            S_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (sts.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.miss_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_REV_CHK:
            begin
                if (sts.rev_more)
                begin
                    cmd.rev_rd = 1'b1;
                    state_next = S_REV_WLO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REV_WLO:
            begin
                cmd.rev_wlo = 1'b1;
                state_next  = S_REV_WHI;
            end
            S_REV_WHI:
            begin
                cmd.rev_whi = 1'b1;
                state_next  = S_REV_CHK;
            end
            S_DONE:
            begin
                if (!sts.busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bstk_dp.sv =====
// Datapath for the bounded stack: entry memory, fill count, pointers,
// search compare and the response register. Driven by bstk_ctrl commands.
// Depends on bstk_pkg.
module bstk_dp
#(
    parameter int DEPTH     = bstk_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bstk_pkg::WORD_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  bstk_pkg::req_t req,
    input  bstk_pkg::cmd_t cmd,
    output bstk_pkg::sts_t sts,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bstk_pkg::rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [WORD_BITS-1:0] mem [DEPTH];

    logic        [2:0]           op_reg;
    logic signed [WORD_BITS-1:0] word_reg;
    logic        [CW-1:0]        count_reg;
    logic        [CW-1:0]        count_m1;
    logic        [IW-1:0]        lo_reg;
    logic        [IW-1:0]        hi_reg;
    logic        [CW-1:0]        ptr_reg;
    logic        [IW-1:0]        cidx_reg;
    logic                        cvld_reg;
    logic signed [WORD_BITS-1:0] rda_reg;
    logic signed [WORD_BITS-1:0] rdb_reg;
    logic        [1:0]           st_reg;
    logic        [IW-1:0]        idx_reg;
    logic                        pop_sel_reg;
    logic                        rsp_valid_reg;
    bstk_pkg::rsp_t              rsp_reg;

    logic                        issue_ok;
    logic                        we;
    logic        [IW-1:0]        waddr;
    logic signed [WORD_BITS-1:0] wdata;
    logic        [IW-1:0]        raddr_a;
    logic                        rd_a;

    assign count_m1 = count_reg - CW'(1);
    assign issue_ok = (ptr_reg < count_reg);

    always_comb
    begin
        we    = cmd.wr_push | cmd.rev_wlo | cmd.rev_whi;
        waddr = hi_reg;
        wdata = rda_reg;
        priority if (cmd.wr_push)
        begin
            waddr = count_reg[IW-1:0];
            wdata = word_reg;
        end
        else if (cmd.rev_wlo)
        begin
            waddr = lo_reg;
            wdata = rdb_reg;
        end
        else
        begin
            waddr = hi_reg;
            wdata = rda_reg;
        end
    end

    always_comb
    begin
        rd_a    = cmd.pop_rd | cmd.srch_step | cmd.rev_rd;
        raddr_a = lo_reg;
        priority if (cmd.pop_rd)
        begin
            raddr_a = count_m1[IW-1:0];
        end
        else if (cmd.srch_step)
        begin
            raddr_a = ptr_reg[IW-1:0];
        end
        else
        begin
            raddr_a = lo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_a)
        begin
            rda_reg <= mem[raddr_a];
        end
        if (cmd.rev_rd)
        begin
            rdb_reg <= mem[hi_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cvld_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.wr_push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop_rd)
            begin
                count_reg <= count_m1;
            end

            if (cmd.srch_init)
            begin
                cvld_reg <= 1'b0;
            end
            else if (cmd.srch_step)
            begin
                cvld_reg <= issue_ok;
            end

            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.opcode;
            word_reg <= WORD_BITS'(req.operand_value);
        end

        if (cmd.srch_init)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.srch_step && issue_ok)
        begin
            ptr_reg <= ptr_reg + CW'(1);
        end

        if (cmd.srch_step)
        begin
            cidx_reg <= ptr_reg[IW-1:0];
        end

        if (cmd.rev_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_m1[IW-1:0];
        end
        else if (cmd.rev_whi)
        begin
            lo_reg <= lo_reg + IW'(1);
            hi_reg <= hi_reg - IW'(1);
        end

        if (cmd.set_found)
        begin
            st_reg  <= bstk_pkg::ST_OK;
            idx_reg <= cidx_reg;
        end
        else if (cmd.set_st)
        begin
            st_reg      <= cmd.st;
            idx_reg     <= '0;
            pop_sel_reg <= cmd.pop_sel;
        end

        if (cmd.emit)
        begin
            rsp_reg.popped_value <= pop_sel_reg ? 32'(rda_reg) : 32'sd0;
            rsp_reg.found_index  <= 4'(idx_reg);
            rsp_reg.status       <= st_reg;
            rsp_reg.fill_count   <= 5'(count_reg);
        end
    end

    assign sts.op        = op_reg;
    assign sts.full      = (count_reg == CW'(DEPTH));
    assign sts.empty     = (count_reg == '0);
    assign sts.multi     = (count_reg > CW'(1));
    assign sts.hit       = cvld_reg && (rda_reg == word_reg);
    assign sts.miss_last = cvld_reg && ((CW'(cidx_reg) + CW'(1)) == count_reg);
    assign sts.rev_more  = (lo_reg < hi_reg);
    assign sts.busy      = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/bounded_stack_with_search_top.sv =====
// Bounded LIFO stack with search, reverse and clear; one response per request.
// Push, pop, clear and unused opcodes: accept, execute, done; the response is registered.
// Search: one entry compared per cycle, from index 0 up; the lowest match is returned.
// Reverse: swaps pairs from both ends inward; one write port does both halves.
// Reset empties the stack (count zero); entry memory is not cleared.
// Depends on bstk_pkg, bstk_ctrl and bstk_dp.
module bounded_stack_with_search_top
#(
    parameter int DEPTH     = bstk_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bstk_pkg::WORD_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bstk_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bstk_pkg::rsp_t rsp
);

    bstk_pkg::cmd_t cmd;
    bstk_pkg::sts_t sts;

    bstk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bstk_dp
    #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== sim/bstk_checker.sv =====
// Response checker for the bounded stack: predicts every accepted request on its own stack copy.
// Compares each accepted response with the oldest prediction; reports mismatches and backlog.
// Depends on bstk_pkg.
module bstk_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  bstk_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  bstk_pkg::rsp_t rsp,
    output int             mismatches,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = bstk_pkg::DEPTH_DEF;

    logic signed [31:0] stack_words [DEPTH];
    int unsigned        stack_fill;
    bstk_pkg::rsp_t     expected_rsp_q [$];
    int                 mismatch_count;

    function automatic bstk_pkg::rsp_t apply_stack_op(bstk_pkg::req_t r);
        bstk_pkg::rsp_t     res;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        i;
        logic signed [31:0] t;
        res = '0;
        res.status = bstk_pkg::ST_OK;
        case (r.opcode)
            bstk_pkg::OP_PUSH:
            begin
                if (stack_fill >= DEPTH)
                begin
                    res.status = bstk_pkg::ST_OVERFLOW;
                end
                else
                begin
                    stack_words[stack_fill] = r.operand_value;
                    stack_fill++;
                end
            end
            bstk_pkg::OP_POP:
            begin
                if (stack_fill == 0)
                begin
                    res.status = bstk_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    stack_fill--;
                    res.popped_value = stack_words[stack_fill];
                end
            end
            bstk_pkg::OP_SEARCH:
            begin
                res.status = bstk_pkg::ST_NOT_FOUND;
                for (i = 0; i < stack_fill; i++)
                begin
                    if (stack_words[i] == r.operand_value)
                    begin
                        res.status      = bstk_pkg::ST_OK;
                        res.found_index = 4'(i);
                        break;
                    end
                end
            end
            bstk_pkg::OP_REVERSE:
            begin
                if (stack_fill > 1)
                begin
                    lo = 0;
                    hi = stack_fill - 1;
                    while (lo < hi)
                    begin
                        t               = stack_words[lo];
                        stack_words[lo] = stack_words[hi];
                        stack_words[hi] = t;
                        lo++;
                        hi--;
                    end
                end
            end
            bstk_pkg::OP_CLEAR:
            begin
                stack_fill = 0;
            end
            default:
            begin
            end
        endcase
        res.fill_count = 5'(stack_fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bstk_pkg::rsp_t want;
        if (!rst_n)
        begin
            stack_fill     = 0;
            mismatch_count = 0;
            expected_rsp_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp_q.push_back(apply_stack_op(req));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: response with no request outstanding:", $realtime);
                        $display("%0t:          got pop %0d idx %0d st %0d cnt %0d",
                                 $realtime, rsp.popped_value, rsp.found_index,
                                 rsp.status, rsp.fill_count);
                    end
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.popped_value !== want.popped_value ||
                        rsp.found_index  !== want.found_index  ||
                        rsp.status       !== want.status       ||
                        rsp.fill_count   !== want.fill_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: mismatch exp pop %0d idx %0d st %0d cnt %0d",
                                     $realtime, want.popped_value, want.found_index,
                                     want.status, want.fill_count);
                            $display("%0t:          got pop %0d idx %0d st %0d cnt %0d",
                                     $realtime, rsp.popped_value, rsp.found_index,
                                     rsp.status, rsp.fill_count);
                        end
                    end
                end
            end
            mismatches <= mismatch_count;
            pending    <= expected_rsp_q.size();
        end
    end

endmodule

// ===== sim/tb_bounded_stack_with_search_top.sv =====
// Testbench top for the bounded stack: clock, reset, request stimulus and response stalls.
// Directed corner requests, then random push/pop/search/reverse/clear and spare-opcode sequences.
// Depends on bstk_pkg, bstk_checker and bounded_stack_with_search_top.
module tb_bounded_stack_with_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int         REQ_TARGET = 1000;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    bstk_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    bstk_pkg::rsp_t rsp;

    int mismatches;
    int pending;

    int                 req_sent = 0;
    int                 fill_est = 0;
    bit                 no_gaps  = 1'b0;
    logic signed [31:0] pushed_pool [$];

    bounded_stack_with_search_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bstk_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] pick_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 9))
            0:       w = 32'h7fff_ffff;
            1:       w = 32'h8000_0000;
            2:       w = '0;
            3:       w = '1;
            4, 5:    w = $urandom_range(0, 7);
            default: w = $urandom();
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] pick_target();
        if (pushed_pool.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
        end
        return pick_word();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [2:0] op, input logic signed [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{opcode: op, operand_value: val};
        do @(posedge clk); while (req_stall);
        req_sent++;
        case (op)
            bstk_pkg::OP_PUSH:
            begin
                if (fill_est < bstk_pkg::DEPTH_DEF)
                begin
                    fill_est++;
                    pushed_pool.push_back(val);
                    if (pushed_pool.size() > 32)
                    begin
                        void'(pushed_pool.pop_front());
                    end
                end
            end
            bstk_pkg::OP_POP:
            begin
                if (fill_est > 0)
                begin
                    fill_est--;
                end
            end
            bstk_pkg::OP_CLEAR:
            begin
                fill_est = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            send_request(bstk_pkg::OP_PUSH, pick_word());
        end
        else if (r < 60)
        begin
            send_request(bstk_pkg::OP_POP, pick_word());
        end
        else if (r < 80)
        begin
            send_request(bstk_pkg::OP_SEARCH, pick_target());
        end
        else if (r < 88)
        begin
            send_request(bstk_pkg::OP_REVERSE, pick_word());
        end
        else if (r < 93)
        begin
            send_request(bstk_pkg::OP_CLEAR, pick_word());
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       send_request(OP_SPARE_5, pick_word());
                1:       send_request(OP_SPARE_6, pick_word());
                default: send_request(OP_SPARE_7, pick_word());
            endcase
        end
    endtask

    initial
    begin
        int  r;
        bit  pressure_done;
        bit  first_scenario;
        pressure_done  = 1'b0;
        first_scenario = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(bstk_pkg::OP_POP, '0);
        send_request(bstk_pkg::OP_SEARCH, '0);
        send_request(bstk_pkg::OP_REVERSE, '0);
        send_request(bstk_pkg::OP_CLEAR, '0);
        send_request(OP_SPARE_5, 32'h5a5a_a5a5);
        send_request(bstk_pkg::OP_PUSH, 32'h7fff_ffff);
        send_request(bstk_pkg::OP_REVERSE, '0);
        send_request(bstk_pkg::OP_SEARCH, 32'h7fff_ffff);
        send_request(bstk_pkg::OP_PUSH, 32'h8000_0000);
        send_request(bstk_pkg::OP_PUSH, '1);
        send_request(bstk_pkg::OP_PUSH, '0);
        send_request(bstk_pkg::OP_PUSH, '1);
        send_request(bstk_pkg::OP_SEARCH, '1);
        send_request(bstk_pkg::OP_SEARCH, 32'h0000_0001);
        send_request(bstk_pkg::OP_REVERSE, '1);
        send_request(bstk_pkg::OP_SEARCH, 32'h7fff_ffff);
        send_request(bstk_pkg::OP_POP, '1);
        send_request(bstk_pkg::OP_POP, '0);
        send_request(OP_SPARE_6, '1);
        send_request(OP_SPARE_7, '0);
        send_request(bstk_pkg::OP_CLEAR, '1);
        send_request(bstk_pkg::OP_POP, 32'h8000_0000);

        while (req_sent < REQ_TARGET)
        begin
            if (!pressure_done && req_sent >= REQ_TARGET / 2)
            begin
                wait_for_drain();
                pressure_done = 1'b1;
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            r = first_scenario ? 0 : $urandom_range(0, 99);
            first_scenario = 1'b0;
            if (r < 15)
            begin
                while (fill_est < bstk_pkg::DEPTH_DEF)
                begin
                    send_request(bstk_pkg::OP_PUSH, pick_word());
                end
                repeat ($urandom_range(1, 3)) send_request(bstk_pkg::OP_PUSH, pick_word());
                repeat ($urandom_range(1, 4)) send_request(bstk_pkg::OP_SEARCH, pick_target());
                send_request(bstk_pkg::OP_REVERSE, pick_word());
                repeat ($urandom_range(1, 3)) send_request(bstk_pkg::OP_SEARCH, pick_target());
            end
            else if (r < 25)
            begin
                while (fill_est > 0)
                begin
                    send_request(bstk_pkg::OP_POP, pick_word());
                end
                repeat ($urandom_range(1, 2)) send_request(bstk_pkg::OP_POP, pick_word());
            end
            else
            begin
                repeat ($urandom_range(5, 30)) send_random_op();
            end
        end

        wait_for_drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        int run;
        int r;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                rsp_stall <= 1'b0;
                run = $urandom_range(50, 200);
            end
            else if (r < 55)
            begin
                rsp_stall <= 1'b0;
                run = $urandom_range(1, 6);
            end
            else if (r < 93)
            begin
                rsp_stall <= 1'b1;
                run = $urandom_range(1, 4);
            end
            else
            begin
                rsp_stall <= 1'b1;
                run = $urandom_range(10, 40);
            end
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
